// ----- rtl/rrmf_pkg.sv -----
// Shared types and constants for the round-robin multi-queue name FIFO.
`timescale 1ns / 1ps

package rrmf_pkg;

  localparam int NUM_QUEUES   = 4;
  localparam int QUEUE_DEPTH  = 16;
  localparam int NAME_W       = 40;
  localparam int DIR_W        = 4;
  localparam int QIDX_W       = $clog2(NUM_QUEUES);
  localparam int PTR_W        = $clog2(QUEUE_DEPTH);
  localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W       = $clog2(NUM_QUEUES * QUEUE_DEPTH);

  typedef enum logic [1:0] {
    CMD_SELECT = 2'd0,
    CMD_PUSH   = 2'd1,
    CMD_DRAIN  = 2'd2,
    CMD_NONE   = 2'd3
  } rrmf_op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADDIR = 2'd2,
    ST_NAME   = 2'd3
  } rrmf_status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_EMIT = 2'd2
  } rrmf_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept_op;  // take the input transaction
    logic rd_issue;   // read head of scanned queue, pop it
    logic skip;       // scanned queue was empty, advance
    logic emit;       // load read name into the output register
  } rrmf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
    logic drain_any;  // at least one queue holds a name
    logic scan_hit;   // scanned queue was non-empty at drain start
    logic scan_last;  // no non-empty queue above the scanned one
  } rrmf_sts_t;

endpackage

// ----- rtl/rrmf_ctrl.sv -----
// Controller: sequences select, push and round-robin drain transactions.
`timescale 1ns / 1ps

module rrmf_ctrl import rrmf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] cmd_i,
  input  rrmf_sts_t  sts_i,
  output logic       in_stall_o,
  output rrmf_cmd_t  cmd_o
);

  rrmf_state_e state_q, state_d;
  logic        take;

  assign in_stall_o = !((state_q == S_IDLE) && sts_i.out_free);
  assign take       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (take && (rrmf_op_e'(cmd_i) == CMD_DRAIN) && sts_i.drain_any) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_hit) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          state_d = sts_i.scan_last ? S_IDLE : S_SCAN;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE: cmd_o.accept_op = take;
      S_SCAN: begin
        cmd_o.rd_issue = sts_i.scan_hit;
        cmd_o.skip     = !sts_i.scan_hit;
      end
      S_EMIT: cmd_o.emit = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ----- rtl/rrmf_dp.sv -----
// Datapath: name store, queue pointers and counts, scan index, output register.
`timescale 1ns / 1ps

module rrmf_dp import rrmf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rrmf_cmd_t         cmd_i,
  input  logic [1:0]        op_i,
  input  logic [DIR_W-1:0]  direction_code_i,
  input  logic [NAME_W-1:0] plane_name_i,
  input  logic              out_stall_i,
  output rrmf_sts_t         sts_o,
  output logic              out_valid_o,
  output logic [1:0]        status_o,
  output logic [NAME_W-1:0] name_out_o,
  output logic [QIDX_W-1:0] from_queue_o,
  output logic              last_o
);

  logic [NAME_W-1:0] mem [NUM_QUEUES*QUEUE_DEPTH];

  logic [PTR_W-1:0]  rptr_q [NUM_QUEUES];
  logic [PTR_W-1:0]  wptr_q [NUM_QUEUES];
  logic [CNT_W-1:0]  cnt_q  [NUM_QUEUES];
  logic [QIDX_W-1:0] cur_dir_q;
  logic [QIDX_W-1:0] idx_q;
  logic [NUM_QUEUES-1:0] mask_q;
  logic [NAME_W-1:0] rd_data_q;

  logic              out_valid_q;
  rrmf_status_e      status_q;
  logic [NAME_W-1:0] name_q;
  logic [QIDX_W-1:0] from_q;
  logic              last_q;

  rrmf_op_e          op;
  logic [NUM_QUEUES-1:0] nonempty;
  logic [NUM_QUEUES-1:0] above;
  logic              dir_ok;
  logic [QIDX_W-1:0] dir_sel;
  logic              push_ok;
  logic              do_push;
  logic              do_select;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic              load_op;

  assign op = rrmf_op_e'(op_i);

  always_comb begin
    for (int j = 0; j < NUM_QUEUES; j++) begin
      nonempty[j] = (cnt_q[j] != '0);
      above[j]    = (QIDX_W'(j) > idx_q);
    end
  end

  assign dir_ok  = (direction_code_i >= DIR_W'(1)) &&
                   (direction_code_i <= DIR_W'(NUM_QUEUES));
  assign dir_sel = QIDX_W'(direction_code_i - DIR_W'(1));
  assign push_ok = (cnt_q[cur_dir_q] < CNT_W'(QUEUE_DEPTH));

  assign do_select = cmd_i.accept_op && (op == CMD_SELECT);
  assign do_push   = cmd_i.accept_op && (op == CMD_PUSH) && push_ok;
  assign load_op   = cmd_i.accept_op && ((op == CMD_SELECT) || (op == CMD_PUSH));

  assign wr_addr = ADDR_W'(cur_dir_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(wptr_q[cur_dir_q]);
  assign rd_addr = ADDR_W'(idx_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(rptr_q[idx_q]);

  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign sts_o.drain_any = |nonempty;
  assign sts_o.scan_hit  = mask_q[idx_q];
  assign sts_o.scan_last = ~|(mask_q & above);

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_addr] <= plane_name_i;
    end
    if (cmd_i.rd_issue) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NUM_QUEUES; j++) begin
        rptr_q[j] <= '0;
        wptr_q[j] <= '0;
        cnt_q[j]  <= '0;
      end
      cur_dir_q <= '0;
      idx_q     <= '0;
      mask_q    <= '0;
    end else begin
      if (do_select && dir_ok) begin
        cur_dir_q <= dir_sel;
      end
      if (do_push) begin
        wptr_q[cur_dir_q] <= (wptr_q[cur_dir_q] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                             wptr_q[cur_dir_q] + PTR_W'(1);
        cnt_q[cur_dir_q]  <= cnt_q[cur_dir_q] + CNT_W'(1);
      end
      // Snapshot which queues take part in this round.
      if (cmd_i.accept_op && (op == CMD_DRAIN)) begin
        mask_q <= nonempty;
        idx_q  <= '0;
      end
      if (cmd_i.rd_issue) begin
        rptr_q[idx_q] <= (rptr_q[idx_q] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                         rptr_q[idx_q] + PTR_W'(1);
        cnt_q[idx_q]  <= cnt_q[idx_q] - CNT_W'(1);
      end
      if (cmd_i.skip || cmd_i.emit) begin
        idx_q <= idx_q + QIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_op || cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_q <= ST_NAME;
      name_q   <= rd_data_q;
      from_q   <= idx_q;
      last_q   <= sts_o.scan_last;
    end else if (load_op) begin
      name_q <= '0;
      last_q <= 1'b1;
      if (op == CMD_SELECT) begin
        status_q <= dir_ok ? ST_OK : ST_BADDIR;
        from_q   <= dir_ok ? dir_sel : cur_dir_q;
      end else begin
        status_q <= push_ok ? ST_OK : ST_FULL;
        from_q   <= cur_dir_q;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign name_out_o   = name_q;
  assign from_queue_o = from_q;
  assign last_o       = last_q;

endmodule

// ----- rtl/round_robin_multi_fifo_top.sv -----
// Top level of the round-robin multi-queue name FIFO.
//
// Input channel (in_valid_i / in_stall_o) carries one command per transaction:
// select a current queue by direction code 1..4, push a 40-bit name to the
// current queue, or drain one round-robin round. Output channel
// (out_valid_o / out_stall_i) returns status, name, queue index and last.
// Select and push give one result, registered when the command is accepted;
// the next command can be taken in the following cycle unless the output stalls.
// A drain walks the queues in index order: for each non-empty queue it reads
// the name store, then loads the output register, and it skips each empty
// queue it passes before the last non-empty one.
// A drain with all queues empty and command 3 give no result.
// Input is stalled while a drain runs and while the output register holds
// a result the receiver stalls; results are held unchanged until taken.
// Reset clears pointers, counts, the current queue (first direction) and
// the output valid; the name store is not cleared.
`timescale 1ns / 1ps

module round_robin_multi_fifo_top import rrmf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        cmd_i,
  input  logic [DIR_W-1:0]  direction_code_i,
  input  logic [NAME_W-1:0] plane_name_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [NAME_W-1:0] name_out_o,
  output logic [QIDX_W-1:0] from_queue_o,
  output logic              last_o
);

  rrmf_cmd_t ctrl_cmd;
  rrmf_sts_t dp_sts;

  rrmf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .sts_i      (dp_sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (ctrl_cmd)
  );

  rrmf_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (ctrl_cmd),
    .op_i             (cmd_i),
    .direction_code_i (direction_code_i),
    .plane_name_i     (plane_name_i),
    .out_stall_i      (out_stall_i),
    .sts_o            (dp_sts),
    .out_valid_o      (out_valid_o),
    .status_o         (status_o),
    .name_out_o       (name_out_o),
    .from_queue_o     (from_queue_o),
    .last_o           (last_o)
  );

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctrl_cmd.accept_op, ctrl_cmd.rd_issue, ctrl_cmd.skip, ctrl_cmd.emit}))
    else $error("controller issued more than one command");

  a_read_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.rd_issue |-> dp_sts.scan_hit)
    else $error("read issued for a queue outside the drain round");

  a_emit_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.rd_issue |=> !in_stall_o == 1'b0)
    else $error("input taken between a store read and its result");

  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.emit |=> out_valid_o && (status_o == ST_NAME))
    else $error("emitted name not presented on the output");

endmodule

// ----- dv/tb_round_robin_multi_fifo_top.sv -----
// Self-checking testbench for the round-robin multi-queue name FIFO.
`timescale 1ns / 1ps

module tb_round_robin_multi_fifo_top;
  import rrmf_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 360;
  localparam int LONG_HOLD    = 200;
  localparam int DRAIN_WAIT   = 20;
  localparam int NUM_ROWS     = 23;

  typedef struct {
    rrmf_status_e      status;
    logic [NAME_W-1:0] name;
    logic [QIDX_W-1:0] queue;
    logic              last;
  } name_result_t;

  typedef struct packed {
    rrmf_op_e          op;
    logic [DIR_W-1:0]  code;
    logic [NAME_W-1:0] name;
    logic [4:0]        reps;
    logic              typed;
    rrmf_status_e      t_status;
    logic [QIDX_W-1:0] t_queue;
  } stim_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [1:0]        cmd_i = CMD_NONE;
  logic [DIR_W-1:0]  direction_code_i = '0;
  logic [NAME_W-1:0] plane_name_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [1:0]        status_o;
  logic [NAME_W-1:0] name_out_o;
  logic [QIDX_W-1:0] from_queue_o;
  logic              last_o;

  // Predictor state: one FIFO of names per direction plus the current queue.
  logic [NAME_W-1:0] held_names [NUM_QUEUES][$];
  logic [QIDX_W-1:0] cur_queue = '0;
  name_result_t      pending_results[$];

  int  error_count = 0;
  int  cycle_count = 0;
  int  holds_asked = 0;
  int  holds_served = 0;
  int  hold_left = 0;
  bit  quiet = 1'b0;
  int  seen_ok = 0, seen_full = 0, seen_baddir = 0, seen_names = 0;
  int  full_drains = 0;

  round_robin_multi_fifo_top dut (.*);

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    error_count++;
  endtask

  function automatic void model_command(input rrmf_op_e op, input logic [DIR_W-1:0] code,
                                        input logic [NAME_W-1:0] name,
                                        output name_result_t outs[$]);
    name_result_t r;
    outs = {};
    r.name = '0;
    r.last = 1'b1;
    case (op)
      CMD_SELECT: begin
        if (code >= 1 && code <= NUM_QUEUES) begin
          cur_queue = QIDX_W'(code - 1);
          r.status = ST_OK;
        end else begin
          r.status = ST_BADDIR;
        end
        r.queue = cur_queue;
        outs.push_back(r);
      end
      CMD_PUSH: begin
        if (held_names[cur_queue].size() >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          held_names[cur_queue].push_back(name);
          r.status = ST_OK;
        end
        r.queue = cur_queue;
        outs.push_back(r);
      end
      CMD_DRAIN: begin
        for (int q = 0; q < NUM_QUEUES; q++) begin
          if (held_names[q].size() != 0) begin
            r.status = ST_NAME;
            r.name   = held_names[q].pop_front();
            r.queue  = QIDX_W'(q);
            r.last   = 1'b0;
            outs.push_back(r);
          end
        end
        if (outs.size() != 0) outs[outs.size()-1].last = 1'b1;
        if (outs.size() == NUM_QUEUES) full_drains++;
      end
      default: ;
    endcase
  endfunction

  // Present one transaction, wait for acceptance, record what must come back.
  // Called and returns at a falling edge.
  task automatic send_command(input rrmf_op_e op, input logic [DIR_W-1:0] code,
                              input logic [NAME_W-1:0] name, input logic typed,
                              input rrmf_status_e t_status,
                              input logic [QIDX_W-1:0] t_queue, output int n_results);
    name_result_t outs[$];
    name_result_t r;
    while (!quiet && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    cmd_i            <= op;
    direction_code_i <= code;
    plane_name_i     <= name;
    do @(posedge clk_i); while (in_stall_o);
    model_command(op, code, name, outs);
    // Single-status rows carry their expected answer in the table.
    if (typed && outs.size() == 1) begin
      r.status = t_status;
      r.name   = '0;
      r.queue  = t_queue;
      r.last   = 1'b1;
      outs[0]  = r;
    end
    foreach (outs[i]) pending_results.push_back(outs[i]);
    n_results = outs.size();
    @(negedge clk_i);
  endtask

  // Receiver: random stalls, a quiet window, and one long hold-off on request.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (holds_served != holds_asked) begin
      holds_served++;
      hold_left = LONG_HOLD - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(99) < 6);
    end
  end

  always @(posedge clk_i) begin
    name_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d name=%h queue=%0d last=%0b",
                                  status_o, name_out_o, from_queue_o, last_o));
      end else begin
        e = pending_results.pop_front();
        if (status_o !== e.status)
          report_mismatch($sformatf("status %0d, expected %0d", status_o, e.status));
        if (name_out_o !== e.name)
          report_mismatch($sformatf("name %h, expected %h", name_out_o, e.name));
        if (from_queue_o !== e.queue)
          report_mismatch($sformatf("queue %0d, expected %0d", from_queue_o, e.queue));
        if (last_o !== e.last)
          report_mismatch($sformatf("last %0b, expected %0b", last_o, e.last));
        case (e.status)
          ST_OK:     seen_ok++;
          ST_FULL:   seen_full++;
          ST_BADDIR: seen_baddir++;
          default:   seen_names++;
        endcase
      end
    end
  end

  stim_row_t directed_rows [NUM_ROWS] = '{
    '{CMD_DRAIN,  4'd0,  40'h0,          5'd1,  1'b0, ST_OK,     2'd0},  // empty drain
    '{CMD_NONE,   4'd0,  40'h0,          5'd1,  1'b0, ST_OK,     2'd0},
    '{CMD_SELECT, 4'd0,  40'h0,          5'd1,  1'b1, ST_BADDIR, 2'd0},
    '{CMD_SELECT, 4'd15, 40'h0,          5'd1,  1'b1, ST_BADDIR, 2'd0},
    '{CMD_SELECT, 4'd5,  40'h0,          5'd1,  1'b1, ST_BADDIR, 2'd0},
    '{CMD_PUSH,   4'd0,  40'hFFFFFFFFFF, 5'd1,  1'b1, ST_OK,     2'd0},
    '{CMD_SELECT, 4'd4,  40'h0,          5'd1,  1'b1, ST_OK,     2'd3},
    '{CMD_PUSH,   4'd15, 40'h0,          5'd1,  1'b1, ST_OK,     2'd3},
    '{CMD_SELECT, 4'd9,  40'h0,          5'd1,  1'b1, ST_BADDIR, 2'd3},  // keeps queue 3
    '{CMD_SELECT, 4'd2,  40'h0,          5'd1,  1'b1, ST_OK,     2'd1},
    '{CMD_PUSH,   4'd0,  40'h41422D3132, 5'd1,  1'b1, ST_OK,     2'd1},
    '{CMD_SELECT, 4'd3,  40'h0,          5'd1,  1'b1, ST_OK,     2'd2},
    '{CMD_PUSH,   4'd0,  40'hAAAAAAAAAA, 5'd1,  1'b1, ST_OK,     2'd2},
    '{CMD_PUSH,   4'd0,  40'h5555555555, 5'd1,  1'b1, ST_OK,     2'd2},
    '{CMD_DRAIN,  4'd0,  40'h0,          5'd1,  1'b0, ST_OK,     2'd0},  // all four queues
    '{CMD_DRAIN,  4'd0,  40'h0,          5'd1,  1'b0, ST_OK,     2'd0},
    '{CMD_DRAIN,  4'd0,  40'h0,          5'd1,  1'b0, ST_OK,     2'd0},
    '{CMD_SELECT, 4'd1,  40'h0,          5'd1,  1'b1, ST_OK,     2'd0},
    '{CMD_PUSH,   4'd0,  40'h4E4F2D3030, 5'd16, 1'b1, ST_OK,     2'd0},  // fill queue 0
    '{CMD_PUSH,   4'd0,  40'h123456789A, 5'd1,  1'b1, ST_FULL,   2'd0},
    '{CMD_NONE,   4'd15, 40'hFFFFFFFFFF, 5'd1,  1'b0, ST_OK,     2'd0},
    '{CMD_DRAIN,  4'd0,  40'h0,          5'd1,  1'b0, ST_OK,     2'd0},
    '{CMD_PUSH,   4'd0,  40'h2D2D2D2D2D, 5'd1,  1'b1, ST_OK,     2'd0}
  };

  initial begin
    int          n_results;
    int          counted;
    int          items_sent;
    int          pick;
    bit          push_phase;
    rrmf_op_e    op;
    logic [DIR_W-1:0]  code;
    logic [63:0] raw;

    counted    = 0;
    items_sent = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      for (int k = 0; k < directed_rows[i].reps; k++) begin
        send_command(directed_rows[i].op, directed_rows[i].code,
                     directed_rows[i].name + NAME_W'(k), directed_rows[i].typed,
                     directed_rows[i].t_status, directed_rows[i].t_queue, n_results);
        items_sent++;
      end
    end

    while (counted < RANDOM_ITEMS) begin
      // Alternate fill-heavy and drain-heavy phases so queues reach full and empty.
      push_phase = ((counted / 60) % 2) == 0;
      quiet      = (counted >= 250 && counted < 330);
      if (counted >= 150 && holds_asked == 0) holds_asked++;
      pick = $urandom_range(99);
      if (pick < (push_phase ? 10 : 15))      op = CMD_SELECT;
      else if (pick < (push_phase ? 75 : 45)) op = CMD_PUSH;
      else if (pick < 95)                     op = CMD_DRAIN;
      else                                    op = CMD_NONE;
      code = ($urandom_range(99) < 85) ? DIR_W'($urandom_range(NUM_QUEUES, 1))
                                       : DIR_W'($urandom_range(15));
      raw = {$urandom(), $urandom()};
      send_command(op, code, raw[NAME_W-1:0], 1'b0, ST_OK, '0, n_results);
      items_sent++;
      if (n_results != 0) counted++;
    end

    in_valid_i <= 1'b0;
    quiet = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Sent %0d commands; %0d names drained, %0d four-queue rounds",
             items_sent, seen_names, full_drains);
    $display("Status seen: %0d accepted, %0d full-queue drops, %0d bad directions",
             seen_ok, seen_full, seen_baddir);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
